// File: design/pdrnz_pkg.sv
// Shared types, constants and codes for the pseudo device port.
package pdrnz_pkg;

  localparam int MAX_ACCESS_BYTES = 64;
  localparam int LEN_W            = 7;
  localparam int DATA_W           = 64;
  localparam int HALF_W           = DATA_W / 2;

  localparam logic [2:0] DEV_NULL   = 3'd0;
  localparam logic [2:0] DEV_ZERO   = 3'd1;
  localparam logic [2:0] DEV_RANDOM = 3'd2;
  localparam logic [2:0] DEV_TOTAL  = 3'd3;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [LEN_W-1:0] SEED_LEN = 7'd8;
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_ACCESS_BYTES);

  localparam logic [DATA_W-1:0] SEED_RESET = 64'd88172645463393265;
  localparam logic [DATA_W-1:0] LCG_MUL    = 64'd6364136223846793005;
  localparam logic [DATA_W-1:0] LCG_ADD    = 64'd42;

  // Work classes decided by the front end.
  typedef enum logic [2:0] {
    OP_FAIL,      // one error result
    OP_SINGLE,    // one plain result, count = length
    OP_ZERO_RD,   // length zero bytes
    OP_RAND_RD,   // length generator bytes
    OP_SEED,      // reseed generator
    OP_TOTAL_RD,  // return byte total
    OP_TOTAL_WR   // add length to byte total
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// File: design/pdrnz_front.sv
// Front end: accepts an access and classifies it into a command.
module pdrnz_front (
  input  logic                          push,
  input  logic                          q_full,
  input  logic                          kind,
  input  logic [2:0]                    device,
  input  logic [pdrnz_pkg::LEN_W-1:0]   length,
  input  logic [pdrnz_pkg::DATA_W-1:0]  write_value,
  output logic                          q_push,
  output pdrnz_pkg::cmd_t               cmd
);

  assign q_push = push & ~q_full;

  always_comb begin
    cmd.op     = pdrnz_pkg::OP_FAIL;
    cmd.length = length;
    cmd.value  = write_value;
    if (length > pdrnz_pkg::MAX_LEN) begin
      cmd.op = pdrnz_pkg::OP_FAIL;
    end else if (kind == pdrnz_pkg::KIND_READ) begin
      case (device)
        pdrnz_pkg::DEV_NULL: begin
          cmd.op     = pdrnz_pkg::OP_SINGLE;
          cmd.length = '0;
        end
        pdrnz_pkg::DEV_ZERO: begin
          cmd.op = (length == '0) ? pdrnz_pkg::OP_SINGLE : pdrnz_pkg::OP_ZERO_RD;
        end
        pdrnz_pkg::DEV_RANDOM: begin
          cmd.op = (length == '0) ? pdrnz_pkg::OP_SINGLE : pdrnz_pkg::OP_RAND_RD;
        end
        pdrnz_pkg::DEV_TOTAL: begin
          cmd.op = (length == pdrnz_pkg::SEED_LEN) ? pdrnz_pkg::OP_TOTAL_RD
                                                   : pdrnz_pkg::OP_FAIL;
        end
        default: cmd.op = pdrnz_pkg::OP_FAIL;
      endcase
    end else begin
      case (device)
        pdrnz_pkg::DEV_NULL:   cmd.op = pdrnz_pkg::OP_SINGLE;
        pdrnz_pkg::DEV_RANDOM: begin
          cmd.op = (length == pdrnz_pkg::SEED_LEN) ? pdrnz_pkg::OP_SEED
                                                   : pdrnz_pkg::OP_FAIL;
        end
        pdrnz_pkg::DEV_TOTAL:  cmd.op = pdrnz_pkg::OP_TOTAL_WR;
        default:               cmd.op = pdrnz_pkg::OP_FAIL;
      endcase
    end
  end

endmodule

// File: design/pdrnz_queue.sv
// Two-entry command queue between front end and back end.
module pdrnz_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  pdrnz_pkg::cmd_t  wr_cmd,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output pdrnz_pkg::cmd_t  rd_cmd
);

  pdrnz_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/pdrnz_back.sv
// Back end: executes commands, owns generator and byte total, holds result register.
module pdrnz_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  pdrnz_pkg::cmd_t               cmd,
  output logic                          cmd_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [pdrnz_pkg::DATA_W-1:0]  data,
  output logic [pdrnz_pkg::LEN_W-1:0]   count,
  output logic                          error,
  output logic                          last
);

  typedef enum logic [1:0] {S_IDLE, S_ZERO, S_MUL, S_ADD} state_t;

  localparam int HW = pdrnz_pkg::HALF_W;
  localparam logic [HW-1:0] MUL_LO = pdrnz_pkg::LCG_MUL[HW-1:0];
  localparam logic [HW-1:0] MUL_HI = pdrnz_pkg::LCG_MUL[pdrnz_pkg::DATA_W-1:HW];

  state_t                         state;
  logic [pdrnz_pkg::DATA_W-1:0]   gen;
  logic [pdrnz_pkg::DATA_W-1:0]   total;
  logic [pdrnz_pkg::LEN_W-1:0]    remain;
  logic [pdrnz_pkg::LEN_W-1:0]    acc_len;
  logic [pdrnz_pkg::DATA_W-1:0]   p_lo;
  logic [HW-1:0]                  p_x1;
  logic [HW-1:0]                  p_x2;
  logic                           res_valid;

  logic                           slot_free;
  logic                           res_load;
  logic [pdrnz_pkg::DATA_W-1:0]   p_lo_next;
  logic [HW-1:0]                  p_x1_next;
  logic [HW-1:0]                  p_x2_next;
  logic [HW-1:0]                  cross_sum;
  logic [pdrnz_pkg::DATA_W-1:0]   gen_next;

  assign slot_free = ~res_valid | pop;
  assign empty     = ~res_valid;

  // low 64 bits of gen * LCG_MUL from three 32x32 partial products
  assign p_lo_next = pdrnz_pkg::DATA_W'(gen[HW-1:0]) * pdrnz_pkg::DATA_W'(MUL_LO);
  assign p_x1_next = gen[pdrnz_pkg::DATA_W-1:HW] * MUL_LO;
  assign p_x2_next = gen[HW-1:0] * MUL_HI;
  assign cross_sum = p_x1 + p_x2;
  assign gen_next  = p_lo + {cross_sum, {HW{1'b0}}} + pdrnz_pkg::LCG_ADD;

  always_comb begin
    cmd_pop = 1'b0;
    if (state == S_IDLE && cmd_valid) begin
      case (cmd.op)
        pdrnz_pkg::OP_ZERO_RD,
        pdrnz_pkg::OP_RAND_RD: cmd_pop = 1'b1;
        default:               cmd_pop = slot_free;
      endcase
    end
  end

  // result register loads a new item this cycle
  always_comb begin
    res_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_pop && cmd.op != pdrnz_pkg::OP_ZERO_RD &&
            cmd.op != pdrnz_pkg::OP_RAND_RD) begin
          res_load = 1'b1;
        end
      end
      S_ZERO,
      S_ADD:   res_load = slot_free;
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      gen       <= pdrnz_pkg::SEED_RESET;
      total     <= '0;
    end else begin
      res_valid <= res_load | (res_valid & ~pop);
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              pdrnz_pkg::OP_ZERO_RD: begin
                remain  <= cmd.length;
                acc_len <= cmd.length;
                state   <= S_ZERO;
              end
              pdrnz_pkg::OP_RAND_RD: begin
                remain  <= cmd.length;
                acc_len <= cmd.length;
                state   <= S_MUL;
              end
              pdrnz_pkg::OP_FAIL: begin
                data      <= '0;
                count     <= '0;
                error     <= 1'b1;
                last      <= 1'b1;
              end
              pdrnz_pkg::OP_SEED: begin
                gen       <= cmd.value;
                data      <= '0;
                count     <= cmd.length;
                error     <= 1'b0;
                last      <= 1'b1;
              end
              pdrnz_pkg::OP_TOTAL_RD: begin
                data      <= total;
                count     <= cmd.length;
                error     <= 1'b0;
                last      <= 1'b1;
              end
              pdrnz_pkg::OP_TOTAL_WR: begin
                total     <= total + pdrnz_pkg::DATA_W'(cmd.length);
                data      <= '0;
                count     <= cmd.length;
                error     <= 1'b0;
                last      <= 1'b1;
              end
              default: begin
                data      <= '0;
                count     <= cmd.length;
                error     <= 1'b0;
                last      <= 1'b1;
              end
            endcase
          end
        end
        S_ZERO: begin
          if (slot_free) begin
            data      <= '0;
            count     <= acc_len;
            error     <= 1'b0;
            last      <= (remain == 7'd1);
            remain    <= remain - 7'd1;
            if (remain == 7'd1) state <= S_IDLE;
          end
        end
        S_MUL: begin
          p_lo  <= p_lo_next;
          p_x1  <= p_x1_next;
          p_x2  <= p_x2_next;
          state <= S_ADD;
        end
        S_ADD: begin
          if (slot_free) begin
            gen       <= gen_next;
            data      <= {56'd0, gen_next[pdrnz_pkg::DATA_W-1:pdrnz_pkg::DATA_W-8]};
            count     <= acc_len;
            error     <= 1'b0;
            last      <= (remain == 7'd1);
            remain    <= remain - 7'd1;
            state     <= (remain == 7'd1) ? S_IDLE : S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/pseudo_device_random_null_zero.sv
// Top level: pseudo device port (null, zero, random, byte total) behind one queue interface.
// A single-result access passes through the command queue, then into the result register.
// Throughput: single-result accesses 1 item per cycle while results are popped; zero and
//   random reads hold the back end; a random byte is a split 64-bit LCG multiply, then add.
// A 2-entry command queue lets the front keep accepting while the back works or stalls.
// Reset (rst, synchronous): queues empty, generator = 88172645463393265, byte total = 0.
module pseudo_device_random_null_zero (
  input  logic                          clk,
  input  logic                          rst,
  // input item side
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [2:0]                    device,
  input  logic [pdrnz_pkg::LEN_W-1:0]   length,
  input  logic [pdrnz_pkg::DATA_W-1:0]  write_value,
  // result side
  input  logic                          pop,
  output logic                          empty,
  output logic [pdrnz_pkg::DATA_W-1:0]  data,
  output logic [pdrnz_pkg::LEN_W-1:0]   count,
  output logic                          error,
  output logic                          last
);

  logic            q_push;
  logic            q_full;
  pdrnz_pkg::cmd_t f_cmd;
  logic            b_valid;
  logic            b_pop;
  pdrnz_pkg::cmd_t b_cmd;

  assign full = q_full;

  // front: range check and device/kind decode into one command per item
  pdrnz_front u_front (
    .push        (push),
    .q_full      (q_full),
    .kind        (kind),
    .device      (device),
    .length      (length),
    .write_value (write_value),
    .q_push      (q_push),
    .cmd         (f_cmd)
  );

  // decoupling queue
  pdrnz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (f_cmd),
    .full     (q_full),
    .rd_en    (b_pop),
    .rd_valid (b_valid),
    .rd_cmd   (b_cmd)
  );

  // back: device state and byte-by-byte result generation
  pdrnz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_pop   (b_pop),
    .pop       (pop),
    .empty     (empty),
    .data      (data),
    .count     (count),
    .error     (error),
    .last      (last)
  );

  // failed access: a single, empty, final result
  assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (count == '0 && data == '0 && last))
    else $error("error result not clean");

  // results never report more than the access cap
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (count <= pdrnz_pkg::MAX_LEN))
    else $error("count above cap");

  // only a count-8 result, such as a total read, may carry more than one byte of data
  assert property (@(posedge clk) disable iff (rst)
    (!empty && count != pdrnz_pkg::SEED_LEN) |-> (data[pdrnz_pkg::DATA_W-1:8] == '0))
    else $error("wide data on byte result");

  // back end only takes a command the queue holds
  assert property (@(posedge clk) disable iff (rst)
    b_pop |-> b_valid)
    else $error("command pop from empty queue");

endmodule

// File: verif/pdrnz_result_check.sv
`timescale 1ns / 100ps
// Result checker for the pseudo device port: predicts each access and compares results in order.
module pdrnz_result_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic                          kind,
  input  logic [2:0]                    device,
  input  logic [pdrnz_pkg::LEN_W-1:0]   length,
  input  logic [pdrnz_pkg::DATA_W-1:0]  write_value,
  input  logic                          pop,
  input  logic                          empty,
  input  logic [pdrnz_pkg::DATA_W-1:0]  data,
  input  logic [pdrnz_pkg::LEN_W-1:0]   count,
  input  logic                          error,
  input  logic                          last,
  output int                            outstanding,
  output int                            mismatches
);

  typedef struct packed {
    logic [pdrnz_pkg::DATA_W-1:0] data;
    logic [pdrnz_pkg::LEN_W-1:0]  count;
    logic                         error;
    logic                         last;
  } access_result_t;

  access_result_t               expected_results[$];
  logic [pdrnz_pkg::DATA_W-1:0] lcg_state;
  logic [pdrnz_pkg::DATA_W-1:0] total_bytes;
  int                           bad_count;

  initial begin
    bad_count   = 0;
    lcg_state   = pdrnz_pkg::SEED_RESET;
    total_bytes = '0;
  end

  // Model of one access: queues every result it will produce, updates the device state.
  task automatic predict_access(input logic k, input logic [2:0] dev,
                                input logic [pdrnz_pkg::LEN_W-1:0] len,
                                input logic [pdrnz_pkg::DATA_W-1:0] wv);
    access_result_t r;
    logic           failed;
    logic           streamed;
    int             i;
    r        = '0;
    r.last   = 1'b1;
    failed   = 1'b0;
    streamed = 1'b0;
    if (len > pdrnz_pkg::MAX_LEN) begin
      failed = 1'b1;
    end else if (k == pdrnz_pkg::KIND_READ) begin
      case (dev)
        pdrnz_pkg::DEV_NULL: ;
        pdrnz_pkg::DEV_ZERO, pdrnz_pkg::DEV_RANDOM: begin
          if (len != '0) begin
            streamed = 1'b1;
            for (i = 0; i < len; i++) begin
              r.data = '0;
              if (dev == pdrnz_pkg::DEV_RANDOM) begin
                lcg_state = lcg_state * pdrnz_pkg::LCG_MUL + pdrnz_pkg::LCG_ADD;
                r.data    = {56'd0, lcg_state[63:56]};
              end
              r.count = len;
              r.error = 1'b0;
              r.last  = (i == len - 1);
              expected_results.push_back(r);
            end
          end
        end
        pdrnz_pkg::DEV_TOTAL: begin
          // total is read as one 8-byte word
          if (len == pdrnz_pkg::SEED_LEN) begin
            r.data  = total_bytes;
            r.count = len;
          end else begin
            failed = 1'b1;
          end
        end
        default: failed = 1'b1;
      endcase
    end else begin
      case (dev)
        pdrnz_pkg::DEV_NULL: r.count = len;
        pdrnz_pkg::DEV_RANDOM: begin
          if (len == pdrnz_pkg::SEED_LEN) begin
            lcg_state = wv;
            r.count   = len;
          end else begin
            failed = 1'b1;
          end
        end
        pdrnz_pkg::DEV_TOTAL: begin
          total_bytes = total_bytes + pdrnz_pkg::DATA_W'(len);
          r.count     = len;
        end
        default: failed = 1'b1;
      endcase
    end
    if (failed) begin
      r       = '0;
      r.error = 1'b1;
      r.last  = 1'b1;
    end
    if (!streamed) expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst) begin
      if (push && !full) predict_access(kind, device, length, write_value);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result data=%h count=%0d error=%b last=%b",
                     $realtime, data, count, error, last);
        end else begin
          want = expected_results.pop_front();
          if (data !== want.data || count !== want.count ||
              error !== want.error || last !== want.last) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                       $realtime, want.data, want.count, want.error, want.last,
                       data, count, error, last);
          end
        end
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= bad_count;
  end

endmodule

// File: verif/tb_pseudo_device_random_null_zero.sv
`timescale 1ns / 100ps
// Testbench top for the pseudo device port: drives accesses, pops results, gives the verdict.
module tb_pseudo_device_random_null_zero;

  // cycles with no item moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 134;

  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           push        = 1'b0;
  logic                           kind        = pdrnz_pkg::KIND_READ;
  logic [2:0]                     device      = pdrnz_pkg::DEV_NULL;
  logic [pdrnz_pkg::LEN_W-1:0]    length      = '0;
  logic [pdrnz_pkg::DATA_W-1:0]   write_value = '0;
  logic                           pop         = 1'b0;
  logic                           full;
  logic                           empty;
  logic [pdrnz_pkg::DATA_W-1:0]   data;
  logic [pdrnz_pkg::LEN_W-1:0]    count;
  logic                           error;
  logic                           last;

  int outstanding;
  int mismatches;
  int tx_idle_pct;           // percent of cycles the sender holds off
  int rx_idle_pct = 83;      // percent of cycles the receiver stalls
  int quiet_cycles = 0;

  pseudo_device_random_null_zero dut (
    .clk, .rst, .push, .full, .kind, .device, .length, .write_value,
    .pop, .empty, .data, .count, .error, .last
  );

  pdrnz_result_check result_check (
    .clk, .rst, .push, .full, .kind, .device, .length, .write_value,
    .pop, .empty, .data, .count, .error, .last,
    .outstanding, .mismatches
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: pop drawn fresh every cycle, held low through reset.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any accepted item on either side clears the counter.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One access. push stays high from item to item unless the sender idles.
  task automatic send_access(input logic k, input logic [2:0] dev,
                             input logic [pdrnz_pkg::LEN_W-1:0] len,
                             input logic [pdrnz_pkg::DATA_W-1:0] wv);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    kind        <= k;
    device      <= dev;
    length      <= len;
    write_value <= wv;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Mostly well-formed accesses with small lengths; some bad devices and lengths.
  task automatic send_random_access();
    logic                        k;
    logic [2:0]                  dev;
    logic [pdrnz_pkg::LEN_W-1:0] len;
    int                          pick;
    k    = 1'($urandom_range(1));
    dev  = 3'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 30)      len = pdrnz_pkg::SEED_LEN;
    else if (pick < 80) len = pdrnz_pkg::LEN_W'($urandom_range(16));
    else if (pick < 93) len = pdrnz_pkg::LEN_W'($urandom_range(63, 17));
    else                len = pdrnz_pkg::MAX_LEN;
    pick = $urandom_range(99);
    if (pick < 8)       dev = 3'($urandom_range(7, 4));
    else if (pick < 14) len = pdrnz_pkg::LEN_W'($urandom_range(127, 65));
    send_access(k, dev, len, {$urandom, $urandom});
  endtask

  initial begin
    tx_idle_pct = 8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every device both ways, length extremes, special cases
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_NULL,   '0,                 '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_NULL,   pdrnz_pkg::MAX_LEN,  '1);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_NULL,   '0,                 '1);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_NULL,   pdrnz_pkg::MAX_LEN,  '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_ZERO,   '0,                 '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_ZERO,   7'd1,               '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_ZERO,   pdrnz_pkg::MAX_LEN,  '0);
    // zero write fails
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_ZERO,   pdrnz_pkg::SEED_LEN, '1);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_RANDOM, '0,                 '0);
    // from the reset seed
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_RANDOM, 7'd5,               '0);
    // short seed rejected
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_RANDOM, 7'd7,               '1);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_RANDOM, pdrnz_pkg::SEED_LEN, '1);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_RANDOM, 7'd3,               '0);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_RANDOM, pdrnz_pkg::SEED_LEN, '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_RANDOM, pdrnz_pkg::MAX_LEN,  '0);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_TOTAL,  pdrnz_pkg::MAX_LEN,  '0);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_TOTAL,  '0,                 '0);
    // wrong size total read
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_TOTAL,  7'd7,               '0);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_TOTAL,  pdrnz_pkg::SEED_LEN, '0);
    // invalid devices
    send_access(pdrnz_pkg::KIND_READ,  3'd4,                  pdrnz_pkg::SEED_LEN, '0);
    send_access(pdrnz_pkg::KIND_WRITE, 3'd7,                  pdrnz_pkg::SEED_LEN, '1);
    // over the length cap; total and seed untouched
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_ZERO,   7'd65,              '0);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_TOTAL,  7'd127,             '1);
    send_access(pdrnz_pkg::KIND_WRITE, pdrnz_pkg::DEV_RANDOM, 7'd72,              '1);
    send_access(pdrnz_pkg::KIND_READ,  pdrnz_pkg::DEV_TOTAL,  pdrnz_pkg::SEED_LEN, '0);

    // random, three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 8;  rx_idle_pct <= 83; end
        1: begin tx_idle_pct = 83; rx_idle_pct <= 8;  end
        default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_access();
    end
    push <= 1'b0;

    // let the last prediction show in outstanding, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
